// ===== hdl/pstk_pkg.sv =====
// ----------------------------------------------------------------------------
// pstk_pkg
// shared types and codes for the bounded priority stack
// ----------------------------------------------------------------------------
package pstk_pkg;

  localparam int VALUE_BITS    = 32;
  localparam int PRIORITY_BITS = 8;
  localparam int COUNT_BITS    = 5;

  // request codes
  localparam logic [1:0] REQ_PUSH   = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_REPORT = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [VALUE_BITS-1:0]    elem_value;
    logic [PRIORITY_BITS-1:0] elem_priority;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]    top_value;
    logic [PRIORITY_BITS-1:0] top_priority;
    logic [COUNT_BITS-1:0]    entry_count;
    logic                     is_empty;
    logic [1:0]               status;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       push;
    logic       pop;
    logic       load_out;
    logic [1:0] status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

// ===== hdl/pstk_ctrl.sv =====
// ----------------------------------------------------------------------------
// pstk_ctrl
// handshake control and request decode for the priority stack
// ----------------------------------------------------------------------------
module pstk_ctrl
  import pstk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_OUT  = 1'b1;

  logic state_r, state_nxt;
  logic in_fire;

  assign out_valid = (state_r == S_OUT);
  assign in_stall  = (state_r == S_OUT) && out_stall;
  assign in_fire   = in_valid && !in_stall;

  always_comb begin
    cmd          = '0;
    cmd.load_out = in_fire;
    cmd.status   = STAT_OK;
    if (in_fire) begin
      case (req_type)
        REQ_PUSH: begin
          if (stat.full) cmd.status = STAT_FULL;
          else           cmd.push   = 1'b1;
        end
        REQ_POP: begin
          if (stat.empty) cmd.status = STAT_EMPTY;
          else            cmd.pop    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_OUT;
      S_OUT: begin
        if (!in_fire && !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== hdl/pstk_dp.sv =====
// ----------------------------------------------------------------------------
// pstk_dp
// sorted cell row, entry count and result register
// ----------------------------------------------------------------------------
module pstk_dp
  import pstk_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  input  logic [VALUE_BITS-1:0]    new_value,
  input  logic [PRIORITY_BITS-1:0] new_priority,
  output dp_stat_t                 stat,
  output out_item_t                result
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [VALUE_BITS-1:0]    val_r   [DEPTH];
  logic [PRIORITY_BITS-1:0] pri_r   [DEPTH];
  logic [VALUE_BITS-1:0]    val_nxt [DEPTH];
  logic [PRIORITY_BITS-1:0] pri_nxt [DEPTH];
  logic [DEPTH-1:0]         above;
  logic [CW-1:0]            count_r, count_nxt;
  out_item_t                result_r;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);

  // cells holding a strictly higher priority stay put on a push
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      above[i] = (CW'(i) < count_r) && (pri_r[i] > new_priority);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      val_nxt[i] = val_r[i];
      pri_nxt[i] = pri_r[i];
      if (cmd.push && !above[i]) begin
        if (i == 0 || above[(i == 0) ? 0 : i - 1]) begin
          val_nxt[i] = new_value;
          pri_nxt[i] = new_priority;
        end else begin
          val_nxt[i] = val_r[(i == 0) ? 0 : i - 1];
          pri_nxt[i] = pri_r[(i == 0) ? 0 : i - 1];
        end
      end else if (cmd.pop && i < DEPTH - 1) begin
        val_nxt[i] = val_r[(i < DEPTH - 1) ? i + 1 : i];
        pri_nxt[i] = pri_r[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.push)     count_nxt = count_r + CW'(1);
    else if (cmd.pop) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      val_r[i] <= val_nxt[i];
      pri_r[i] <= pri_nxt[i];
    end
    if (cmd.load_out) begin
      result_r.is_empty     <= (count_nxt == '0);
      result_r.top_value    <= (count_nxt == '0) ? '0 : val_nxt[0];
      result_r.top_priority <= (count_nxt == '0) ? '0 : pri_nxt[0];
      result_r.entry_count  <= COUNT_BITS'(count_nxt);
      result_r.status       <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else        count_r <= count_nxt;
  end

  assign result = result_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> count_r == $past(count_r) + CW'(1))
    else $error("push did not grow the count");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> count_r == $past(count_r) - CW'(1))
    else $error("pop did not shrink the count");

  a_top_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CW'(2) |-> pri_r[0] >= pri_r[1])
    else $error("top two cells out of order");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !cmd.push)
    else $error("push taken on a full store");

endmodule

// ===== hdl/priority_stack_lifo_ties.sv =====
// ----------------------------------------------------------------------------
// priority_stack_lifo_ties
// bounded priority stack with last-in first-out order among equal priorities
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid / in_stall / in_data): one request per transfer,
//   push, pop or report only (any other code reports only)
//   out channel (out_valid / out_stall / out_data): exactly one result per
//   request, in request order: top entry, priority, count, empty flag, status
//   latency: the result is shown the cycle after the request transfer
//   throughput: one request per cycle; a push compares every cell against the
//   new priority in parallel and the whole cell row shifts in that cycle
//   the result register lets a new request in while the last result is
//   taken in the same cycle; while the receiver stalls a waiting result,
//   in_stall is raised and the store does not change
//   reset: the count clears to zero, no result is pending; the cell contents
//   are left as they are and only cells below the count are ever looked at
//   a push on a full store is dropped with status full, a pop on an empty
//   store is refused with status empty
// ----------------------------------------------------------------------------
module priority_stack_lifo_ties
  import pstk_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // command and status between controller and cell row
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // handshake, request decode and full / empty checks
  pstk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (in_data.req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // sorted cells, top at index 0, and the result register
  pstk_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .new_value    (in_data.elem_value),
    .new_priority (in_data.elem_priority),
    .stat         (stat),
    .result       (out_data)
  );

endmodule

// ===== tb/priority_stack_lifo_ties_tb.sv =====
// ----------------------------------------------------------------------------
// priority_stack_lifo_ties_tb
// self-checking bench for the bounded priority stack: a clocked driver feeds
// requests from a queue, a clocked monitor checks every result against a
// local sorted-store predictor, with random idling on both channels
// ----------------------------------------------------------------------------
module priority_stack_lifo_ties_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pstk_pkg::*;

  localparam int DEPTH = 16;
  // the block treats the spare request code as report only
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int RANDOM_REQUESTS = 1700;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  priority_stack_lifo_ties #(
    .DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 2 ns period
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // --------------------------------------------------------------------------
  // predictor: our own copy of the sorted store, index 0 is the top
  // --------------------------------------------------------------------------
  logic [VALUE_BITS-1:0]    held_value [DEPTH];
  logic [PRIORITY_BITS-1:0] held_prio  [DEPTH];
  int                       held_count = 0;

  in_item_t  pending_requests [$];   // requests not yet offered
  out_item_t expected_reports [$];   // reports still owed by the block

  int  fail_count   = 0;
  int  reports_seen = 0;
  bit  req_taken    = 1'b0;          // set at the edge that takes a request
  int  send_gap     = 0;
  bit  send_burst   = 1'b0;
  int  stall_left   = 0;
  bit  recv_burst   = 1'b0;

  // applies one request to the local store and returns the report it causes
  function automatic out_item_t stack_apply(in_item_t req);
    out_item_t report;
    int        slot;
    report.status = STAT_OK;
    case (req.req_type)
      REQ_PUSH: begin
        if (held_count >= DEPTH) begin
          report.status = STAT_FULL;
        end else begin
          // new entry goes ahead of every equal or lower priority
          slot = 0;
          while (slot < held_count && held_prio[slot] > req.elem_priority) slot++;
          for (int k = held_count; k > slot; k--) begin
            held_value[k] = held_value[k-1];
            held_prio[k]  = held_prio[k-1];
          end
          held_value[slot] = req.elem_value;
          held_prio[slot]  = req.elem_priority;
          held_count++;
        end
      end
      REQ_POP: begin
        if (held_count == 0) begin
          report.status = STAT_EMPTY;
        end else begin
          for (int k = 1; k < held_count; k++) begin
            held_value[k-1] = held_value[k];
            held_prio[k-1]  = held_prio[k];
          end
          held_count--;
        end
      end
      default: begin
        // report only, store untouched
      end
    endcase
    if (held_count == 0) begin
      report.top_value    = '0;
      report.top_priority = '0;
      report.is_empty     = 1'b1;
    end else begin
      report.top_value    = held_value[0];
      report.top_priority = held_prio[0];
      report.is_empty     = 1'b0;
    end
    report.entry_count = COUNT_BITS'(held_count);
    return report;
  endfunction

  function automatic in_item_t make_request(logic [1:0] kind,
                                            logic [VALUE_BITS-1:0] value,
                                            logic [PRIORITY_BITS-1:0] prio);
    in_item_t item;
    item.req_type      = kind;
    item.elem_value    = value;
    item.elem_priority = prio;
    return item;
  endfunction

  // random priority, weighted towards a few values so ties are common
  function automatic logic [PRIORITY_BITS-1:0] pick_priority();
    case ($urandom_range(0, 3))
      0:       return PRIORITY_BITS'($urandom_range(0, 3));
      1:       return $urandom_range(0, 1) ? '1 : '0;
      2:       return PRIORITY_BITS'($urandom_range(250, 255));
      default: return PRIORITY_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // request driver: changes on the falling edge, holds a stalled payload
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_requests
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      // transfer still stalled, keep valid and payload steady
    end else begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        in_data  <= pending_requests.pop_front();
        in_valid <= 1'b1;
        // occasionally switch between gappy traffic and back-to-back bursts
        if ($urandom_range(0, 99) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // request side monitor: every accepted transfer updates the predictor
  always @(posedge clk) begin : watch_requests
    if (rst_n && in_valid && !in_stall) begin
      expected_reports.push_back(stack_apply(in_data));
      req_taken = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // result receiver: stall counted down on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result monitor: field-by-field comparison against the oldest expectation
  always @(posedge clk) begin : check_reports
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $error("report transfer with no request outstanding: %p", out_data);
        fail_count++;
      end else begin
        want = expected_reports.pop_front();
        if (out_data.top_value !== want.top_value) begin
          $error("top_value: expected %h, got %h", want.top_value, out_data.top_value);
          fail_count++;
        end
        if (out_data.top_priority !== want.top_priority) begin
          $error("top_priority: expected %h, got %h",
                 want.top_priority, out_data.top_priority);
          fail_count++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d",
                 want.entry_count, out_data.entry_count);
          fail_count++;
        end
        if (out_data.is_empty !== want.is_empty) begin
          $error("is_empty: expected %b, got %b", want.is_empty, out_data.is_empty);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
      end
      reports_seen++;
      if ($urandom_range(0, 99) == 0) recv_burst = !recv_burst;
      stall_left = recv_burst ? 0 : $urandom_range(0, 3);
      // long hold-offs: the block backs up and must stall the sender
      if (reports_seen == 400 || reports_seen == 1100) stall_left = 60;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int segment_left;
    int push_pct;
    int roll;
    logic [1:0] kind;

    // directed: empty-store corner cases first
    pending_requests.push_back(make_request(REQ_POP,    '0, '0));  // pop on empty
    pending_requests.push_back(make_request(REQ_REPORT, '1, '1));
    pending_requests.push_back(make_request(REQ_SPARE,  '1, '1));  // spare code
    // popping the last entry must clear the top
    pending_requests.push_back(make_request(REQ_PUSH,   '0, '0));
    pending_requests.push_back(make_request(REQ_POP,    '0, '0));
    // extremes and equal-priority ordering
    pending_requests.push_back(make_request(REQ_PUSH, 32'hFFFF_FFFF, 8'hFF));
    pending_requests.push_back(make_request(REQ_PUSH, 32'h1111_1111, 8'h80));
    pending_requests.push_back(make_request(REQ_PUSH, 32'h2222_2222, 8'h80));
    pending_requests.push_back(make_request(REQ_PUSH, 32'h3333_3333, 8'hFF));
    pending_requests.push_back(make_request(REQ_PUSH, 32'h0000_0000, 8'h00));
    pending_requests.push_back(make_request(REQ_PUSH, 32'hA5A5_A5A5, 8'h01));
    pending_requests.push_back(make_request(REQ_REPORT, '0, '0));
    // fill to capacity, then a dropped push and a spare-code report when full
    for (int k = 0; k < 10; k++) begin
      pending_requests.push_back(make_request(REQ_PUSH, 32'h5A5A_0000 + k,
                                              PRIORITY_BITS'((k % 3) * 8'h40)));
    end
    pending_requests.push_back(make_request(REQ_PUSH, 32'hDEAD_BEEF, 8'hFF));
    pending_requests.push_back(make_request(REQ_SPARE, '0, '0));

    // random: segments biased towards filling, draining or churning
    segment_left = 0;
    push_pct     = 50;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (segment_left == 0) begin
        segment_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      segment_left--;
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
        kind = REQ_PUSH;
      end else if (roll < 94) begin
        kind = REQ_POP;
      end else if (roll < 97) begin
        kind = REQ_REPORT;
      end else begin
        kind = REQ_SPARE;
      end
      pending_requests.push_back(make_request(kind, pick_value(), pick_priority()));
    end

    // reset held, then released on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain: everything offered and every report back
    while (pending_requests.size() != 0 || in_valid || expected_reports.size() != 0) begin
      @(posedge clk);
    end
    // keep the clock running after the drain so a stray extra report would still be caught
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pstk_pkg.sv
hdl/pstk_ctrl.sv
hdl/pstk_dp.sv
hdl/priority_stack_lifo_ties.sv
tb/priority_stack_lifo_ties_tb.sv
